[design/gtin_cd_pkg.sv]
// Package for the GTIN/UPC mod-10 check digit block.
// Holds the character codes, the digit bound and the small mod-10 helpers.
// No dependencies.
package gtin_cd_pkg;

  localparam int unsigned MAX_DIGITS = 255;
  localparam int unsigned COUNT_CAP  = 255;

  localparam logic [7:0] CODE_ZERO = 8'h30;
  localparam logic [7:0] CODE_NINE = 8'h39;

  localparam logic [11:0] MAX_DIGITS_W = 12'(MAX_DIGITS);
  localparam logic [11:0] COUNT_CAP_W  = 12'(COUNT_CAP);

  // Output stream payload: check digit in the low nibble, count above it.
  typedef struct packed {
    logic [7:0] digit_count;
    logic [3:0] check_digit;
  } gtin_cd_result_t;

  // Digit limit in effect: zero selects the bound, and the bound and the
  // counter width both cap the setting.
  function automatic logic [7:0] digit_limit(input logic [7:0] setting);
    logic [11:0] lim;
    begin
      lim = (setting == 8'd0) ? MAX_DIGITS_W : {4'd0, setting};
      if (lim > MAX_DIGITS_W) begin
        lim = MAX_DIGITS_W;
      end
      if (lim > COUNT_CAP_W) begin
        lim = COUNT_CAP_W;
      end
      return lim[7:0];
    end
  endfunction

  // Adds one decimal digit to a running sum kept below ten.
  function automatic logic [3:0] add_mod10(input logic [3:0] acc, input logic [3:0] d);
    logic [4:0] s;
    begin
      s = {1'b0, acc} + {1'b0, d};
      if (s >= 5'd10) begin
        s = s - 5'd10;
      end
      return s[3:0];
    end
  endfunction

  // Check digit from the weight-3 and weight-1 partial sums (each below ten).
  function automatic logic [3:0] check_of(input logic [3:0] heavy, input logic [3:0] light);
    logic [5:0] s;
    begin
      s = {1'b0, heavy, 1'b0} + {2'd0, heavy} + {2'd0, light};
      if (s >= 6'd30) begin
        s = s - 6'd30;
      end else if (s >= 6'd20) begin
        s = s - 6'd20;
      end else if (s >= 6'd10) begin
        s = s - 6'd10;
      end
      return (s == 6'd0) ? 4'd0 : 4'(6'd10 - s);
    end
  endfunction

endpackage

[design/gtin_check_digit_top.sv]
// GTIN/UPC mod-10 check digit over a character stream: top level.
// Depends on gtin_cd_pkg for constants and the mod-10 helpers.
//
// Usage:
// Characters arrive one item per cycle on the s_axis channel. tdata is
// the ASCII code; tlast marks the end-of-string item, whose character is
// ignored. Only the codes '0'..'9' are kept, and only until the digit
// limit is reached. The limit is set through cfg_we/cfg_wdata: zero
// means up to MAX_DIGITS. Write it only while the block is idle.
// Each end-of-string item yields one result on m_axis: the check digit
// (weight 3 on the rightmost kept digit, alternating with 1 leftward)
// and the number of kept digits. The sums then clear for the next string.
// Timing: an accepted item is first held in the input register; from there
// the sums update and an end-of-string result is loaded into the output
// register, which drives m_axis_tvalid. One item is taken every cycle
// unless an end-of-string item stalls. When the receiver holds
// m_axis_tready low, the result waits in the output register; characters
// keep flowing, and only a second end-of-string item stalls in the input
// register until the output register frees up. Reset (rst, synchronous)
// clears the sums, the count, the limit setting and both valid flags.
module gtin_check_digit_top
  import gtin_cd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,      // payload_digits
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // end_of_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [3:0] check_digit, [11:4] digit_count, rest zero
);

  // Limit setting.
  logic [7:0] payload_digits;

  // Input register.
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_eos;

  // Running string state.
  logic [3:0] even_index_sum;
  logic [3:0] odd_index_sum;
  logic [7:0] kept_count;

  // Output register.
  logic            out_valid;
  gtin_cd_result_t out_result;

  logic            out_free;
  logic            in_advance;
  logic            keep_digit;
  logic [3:0]      digit;
  logic [3:0]      heavy;
  logic [3:0]      light;
  gtin_cd_result_t result_next;

  // The output register can take a new result when empty or being drained.
  assign out_free   = !out_valid || m_axis_tready;
  // A character always retires; an end-of-string item needs the output slot.
  assign in_advance = in_valid && (!in_eos || out_free);
  assign s_axis_tready = !in_valid || in_advance;

  assign digit = 4'(in_char - CODE_ZERO);
  assign keep_digit = in_valid && !in_eos && (in_char >= CODE_ZERO) && (in_char <= CODE_NINE)
                      && (kept_count < digit_limit(payload_digits));

  // The rightmost kept digit sits at position kept_count - 1.
  always_comb begin
    if (kept_count[0]) begin
      heavy = even_index_sum;
      light = odd_index_sum;
    end else begin
      heavy = odd_index_sum;
      light = even_index_sum;
    end
    result_next.check_digit = check_of(heavy, light);
    result_next.digit_count = kept_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_digits <= 8'd0;
    end else if (cfg_we) begin
      payload_digits <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      in_char <= s_axis_tdata;
      in_eos  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      even_index_sum <= 4'd0;
      odd_index_sum  <= 4'd0;
      kept_count     <= 8'd0;
    end else if (in_advance && in_eos) begin
      even_index_sum <= 4'd0;
      odd_index_sum  <= 4'd0;
      kept_count     <= 8'd0;
    end else if (keep_digit) begin
      if (kept_count[0]) begin
        odd_index_sum <= add_mod10(odd_index_sum, digit);
      end else begin
        even_index_sum <= add_mod10(even_index_sum, digit);
      end
      kept_count <= kept_count + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_advance && in_eos) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance && in_eos) begin
      out_result <= result_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_result};

endmodule

[tb/gtin_cd_check_monitor.sv]
// Watches the character and result streams of the check digit block, predicts
// each result and compares it with what the block delivers.
// Depends on gtin_cd_pkg for the character codes, the digit bound and the result type.
module gtin_cd_check_monitor
  import gtin_cd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  output int          mismatches,
  output int          results_due
);

  gtin_cd_result_t digits_awaited[$];

  logic [7:0] limit_setting;
  logic [3:0] even_sum;
  logic [3:0] odd_sum;
  logic [7:0] kept;

  function automatic logic [7:0] kept_limit(input logic [7:0] setting);
    int unsigned lim;
    lim = (setting == 8'd0) ? MAX_DIGITS : int'(setting);
    if (lim > MAX_DIGITS) begin
      lim = MAX_DIGITS;
    end
    if (lim > COUNT_CAP) begin
      lim = COUNT_CAP;
    end
    return 8'(lim);
  endfunction

  // The rightmost kept digit carries weight 3, so the parity of the count
  // decides which of the two partial sums is the heavy one.
  function automatic gtin_cd_result_t close_string(input logic [3:0] evens,
                                                   input logic [3:0] odds,
                                                   input logic [7:0] count);
    gtin_cd_result_t res;
    int unsigned heavy;
    int unsigned light;
    int unsigned total;
    heavy = count[0] ? evens : odds;
    light = count[0] ? odds : evens;
    total = (3 * heavy + light) % 10;
    res.check_digit = 4'((10 - total) % 10);
    res.digit_count = count;
    return res;
  endfunction

  task automatic note_mismatch(input string what, input gtin_cd_result_t want,
                               input logic [15:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at %0t: %s, expected digit %0d count %0d, got tdata 0x%04h",
               $realtime, what, want.check_digit, want.digit_count, got);
    end
  endtask

  always @(posedge clk) begin
    gtin_cd_result_t want;
    int unsigned d;
    if (rst) begin
      limit_setting = 8'd0;
      even_sum      = 4'd0;
      odd_sum       = 4'd0;
      kept          = 8'd0;
      mismatches    = 0;
    end else begin
      if (cfg_we) begin
        limit_setting = cfg_wdata;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (digits_awaited.size() == 0) begin
          note_mismatch("result with none outstanding", '0, m_axis_tdata);
        end else begin
          want = digits_awaited.pop_front();
          if (m_axis_tdata[3:0] != want.check_digit) begin
            note_mismatch("check_digit differs", want, m_axis_tdata);
          end
          if (m_axis_tdata[11:4] != want.digit_count) begin
            note_mismatch("digit_count differs", want, m_axis_tdata);
          end
          if (m_axis_tdata[15:12] != 4'd0) begin
            note_mismatch("padding bits not zero", want, m_axis_tdata);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tlast) begin
          digits_awaited.push_back(close_string(even_sum, odd_sum, kept));
          even_sum = 4'd0;
          odd_sum  = 4'd0;
          kept     = 8'd0;
        end else if (s_axis_tdata >= CODE_ZERO && s_axis_tdata <= CODE_NINE &&
                     kept < kept_limit(limit_setting)) begin
          d = s_axis_tdata - CODE_ZERO;
          if (kept[0]) begin
            odd_sum = 4'((odd_sum + d) % 10);
          end else begin
            even_sum = 4'((even_sum + d) % 10);
          end
          kept = kept + 8'd1;
        end
      end
    end
    results_due = digits_awaited.size();
  end

endmodule

[tb/gtin_check_digit_top_tb.sv]
// Testbench top for the GTIN/UPC check digit block: clock, reset, character
// stimulus, receiver back-pressure and the final verdict.
// Depends on gtin_cd_pkg, gtin_check_digit_top and gtin_cd_check_monitor.
module gtin_check_digit_top_tb;
  import gtin_cd_pkg::*;

  localparam int PHASE_ITEMS = 80;
  localparam int HOLD_CYCLES = 300;

  // Every input of the block starts from a known value; reset is high
  // from time zero.
  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_we        = 1'b0;
  logic [7:0]  cfg_wdata     = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] char_code
  logic        s_axis_tlast  = 1'b0;   // end_of_string
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [3:0] check_digit, [11:4] digit_count

  // Knobs that the stimulus process sets for the current phase.
  logic tx_idle  = 1'b0;
  logic rx_idle  = 1'b0;
  logic hold_req = 1'b0;

  int mismatches;
  int results_due;
  int items_sent = 0;

  gtin_check_digit_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  gtin_cd_check_monitor u_watch (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .results_due   (results_due)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(12 * 200000);
    $display("TEST FAILED");
    $finish;
  end

  // Receiver. A rising hold_req starts a long hold-off that this process
  // counts down on its own; otherwise tready is either random (about 30
  // percent low) or held high.
  int hold_left  = 0;
  bit hold_armed = 1'b0;

  always @(posedge clk) begin
    if (hold_req && !hold_armed) begin
      hold_armed = 1'b1;
      hold_left  = HOLD_CYCLES;
    end else if (!hold_req) begin
      hold_armed = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_idle) begin
      m_axis_tready <= ($urandom_range(99) >= 30);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Offers one item and returns at the clock edge where it was accepted.
  // The caller always resumes right after a rising edge. tvalid stays high
  // into the next item unless an idle gap is inserted, so it is never
  // lowered and raised within the same time step.
  task automatic send_item(input logic [7:0] code, input logic eos);
    if (tx_idle && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < 30);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    s_axis_tlast  <= eos;
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
    items_sent++;
  endtask

  // Mostly digits, with plain noise and codes right beside the digit range
  // mixed in. The end-of-string item carries a random, ignored character.
  task automatic send_string(input int len, input bit close);
    int r;
    logic [7:0] code;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 80) begin
        code = CODE_ZERO + 8'($urandom_range(9));
      end else if (r < 90) begin
        code = 8'($urandom_range(255));
      end else begin
        case ($urandom_range(3))
          0: code = CODE_ZERO - 8'd1;
          1: code = CODE_NINE + 8'd1;
          2: code = 8'h00;
          default: code = 8'hFF;
        endcase
      end
      send_item(code, 1'b0);
    end
    if (close) begin
      send_item(8'($urandom_range(255)), 1'b1);
    end
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      send_item(text[i], 1'b0);
    end
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  // Stops the sender, lets every outstanding result drain and the input
  // register settle, then writes a new digit limit. The extra edge before
  // the wait makes sure the monitor has seen the last accepted item.
  task automatic quiesce_and_set_limit(input logic [7:0] setting);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (results_due == 0);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= setting;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  logic [7:0] phase_limit [8];

  initial begin
    int phase_start;
    phase_limit = '{8'd12, 8'd1, 8'd255, 8'd13, 8'd0, 8'd7, 8'd2, 8'd0};
    phase_limit[7] = 8'($urandom_range(255));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed strings under the reset limit (zero, so the full bound).
    // An empty string, the two extreme digits alone, a string of only
    // non-digits including code zero and the codes next to the digit range,
    // and two known payloads.
    send_item(8'hFF, 1'b1);
    send_text("0");
    send_text("9");
    send_item(8'h00, 1'b0);
    send_item(CODE_ZERO - 8'd1, 1'b0);
    send_item(CODE_NINE + 8'd1, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b1);
    send_text("036000291452");
    send_text("40063813339");

    for (int phase = 0; phase < 8; phase++) begin
      quiesce_and_set_limit(phase_limit[phase]);
      // Phase zero runs without any idling on either side;
      // the others idle at random.
      tx_idle  <= (phase != 0);
      rx_idle  <= (phase != 0);
      // Phase three starts with the receiver held off while strings keep
      // coming, so the output register fills and the input stalls.
      hold_req <= (phase == 3);
      phase_start = items_sent;

      // Strings longer than the bound at the two settings that allow it.
      if (phase == 2 || phase == 4) begin
        for (int i = 0; i < 260; i++) begin
          send_item(CODE_ZERO + 8'($urandom_range(9)), 1'b0);
        end
        send_item(8'($urandom_range(255)), 1'b1);
      end

      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(9) == 0) begin
          send_string($urandom_range(0, 40), 1'b1);
        end else begin
          send_string($urandom_range(0, 16), 1'b1);
        end
      end

      // Leave a string open so the next limit takes effect mid-string.
      if (phase == 5) begin
        send_string($urandom_range(1, 6), 1'b0);
      end
    end

    s_axis_tvalid <= 1'b0;
    hold_req      <= 1'b0;
    @(posedge clk);
    wait (results_due == 0);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && results_due == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
